>>> rtl/aml_sleep_package_scanner_defines.svh
// Assertion macros shared by the sleep package scanner RTL.
`ifndef AML_SLEEP_PACKAGE_SCANNER_DEFINES_SVH
`define AML_SLEEP_PACKAGE_SCANNER_DEFINES_SVH
`ifndef SYNTHESIS
`define ASPS_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("asps: assertion failed");
`define ASPS_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("asps: assertion failed");
`else
`define ASPS_ASSERT(name, clk, rst, prop)
`define ASPS_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

>>> rtl/asps_pkg.sv
// Types, constants and the integer-constant decoder of the sleep package scanner.
`default_nettype none
package asps_pkg;

  localparam int unsigned WINDOW_BYTES_DEF = 70;
  localparam int unsigned TAPS = 13;
  localparam int unsigned SLEEP_W = 3;
  localparam int unsigned CFG_INDEX_W = 1;

  localparam logic [SLEEP_W-1:0] DEF_SLEEP = 3'd5;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_DEF_A = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_DEF_B = 1'b1;

  // name and opcodes
  localparam logic [7:0] CH_UNDER   = 8'h5F;
  localparam logic [7:0] CH_S       = 8'h53;
  localparam logic [7:0] CH_5       = 8'h35;
  localparam logic [7:0] OP_PACKAGE = 8'h12;
  localparam logic [7:0] OP_ZERO    = 8'h00;
  localparam logic [7:0] OP_ONE     = 8'h01;
  localparam logic [7:0] OP_ONES    = 8'hFF;
  localparam logic [7:0] OP_BYTE    = 8'h0A;
  localparam logic [7:0] OP_WORD    = 8'h0B;
  localparam logic [7:0] LEN_BAD    = 8'h80;
  localparam logic [5:0] LEN_MASK   = 6'h3F;
  localparam logic [7:0] MIN_COUNT  = 8'd2;
  localparam logic [7:0] MAX_SLEEP  = 8'd7;
  localparam logic [7:0] ELEM_OFS   = 8'd7;

  typedef struct packed {
    logic               ok;
    logic               fits;    // value fits in a sleep type
    logic [SLEEP_W-1:0] val;
    logic [1:0]         size;
  } const_t;

  typedef struct packed {
    logic append;       // byte accepted: shift in at the tail
    logic enter_drain;  // accepted byte is the last one
    logic align;        // drain: shift until oldest byte sits at the head
    logic step;         // drain: drop head after its test
    logic test_en;      // test the head position this cycle
    logic finish;       // load result and clear table state
  } cmd_t;

  typedef struct packed {
    logic fill_full;
    logic fill_le_one;
    logic lead_zero;
    logic matched;
    logic out_free;
  } stat_t;

  function automatic const_t decode_const(input logic [7:0] op, input logic [7:0] b1,
                                          input logic [7:0] b2, input logic [6:0] room);
    const_t c;
    c = '0;
    case (op)
      OP_ZERO: begin
        c.ok = 1'b1; c.fits = 1'b1; c.val = 3'd0; c.size = 2'd1;
      end
      OP_ONE: begin
        c.ok = 1'b1; c.fits = 1'b1; c.val = 3'd1; c.size = 2'd1;
      end
      OP_ONES: begin
        c.ok = 1'b1; c.fits = 1'b0; c.size = 2'd1;
      end
      OP_BYTE: begin
        if (room >= 7'd2) begin
          c.ok = 1'b1; c.fits = (b1 <= MAX_SLEEP); c.val = b1[2:0]; c.size = 2'd2;
        end
      end
      OP_WORD: begin
        if (room >= 7'd3) begin
          c.ok = 1'b1; c.fits = (b2 == 8'd0) && (b1 <= MAX_SLEEP);
          c.val = b1[2:0]; c.size = 2'd3;
        end
      end
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

>>> rtl/asps_if.sv
// Stream channels of the sleep package scanner: table bytes in, result out.
`default_nettype none
interface asps_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface asps_result_if;
  logic       valid;
  logic       ready;
  logic       found;
  logic [2:0] sleep_type_a;
  logic [2:0] sleep_type_b;
  modport source (output valid, output found, output sleep_type_a, output sleep_type_b,
                  input ready);
  modport sink (input valid, input found, input sleep_type_a, input sleep_type_b,
                output ready);
endinterface
`default_nettype wire

>>> rtl/aml_sleep_package_scanner.sv
// Top level of the sleep package scanner.
//
//   channel   dir  word                                  handshake
//   stream    in   data_byte[7:0], last_byte             valid/ready
//   result    out  found, sleep_type_a[2:0], sleep_type_b[2:0]  valid/ready
//   cfg_*     in   cfg_index selects default A/B, cfg_data[2:0]   write enable
//
// Streaming: one byte per cycle unless draining; the head is tested as it leaves.
// After the last byte the window is drained: WINDOW_BYTES - fill alignment shifts,
// then one head test per cycle.
// The result sits in an output register; bytes of the next table are accepted
// while it waits, but the drain does not finish until that register is free.
// Synchronous reset clears control state and sets both defaults to 5.
`default_nettype none
module aml_sleep_package_scanner #(
  parameter int unsigned WINDOW_BYTES = asps_pkg::WINDOW_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  asps_byte_if.sink                        stream,
  asps_result_if.source                    result,
  input  logic                             cfg_write,
  input  logic [asps_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [asps_pkg::SLEEP_W-1:0]     cfg_data
);
  import asps_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  asps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (stream.valid),
    .in_last  (stream.last_byte),
    .in_ready (stream.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  asps_datapath #(
    .WINDOW_BYTES (WINDOW_BYTES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .data_byte    (stream.data_byte),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .out_ready    (result.ready),
    .out_valid    (result.valid),
    .found        (result.found),
    .sleep_type_a (result.sleep_type_a),
    .sleep_type_b (result.sleep_type_b)
  );

endmodule
`default_nettype wire

>>> rtl/asps_datapath.sv
// Byte window shift line, head position test, config and result registers.
`default_nettype none
`include "aml_sleep_package_scanner_defines.svh"
module asps_datapath #(
  parameter int unsigned WINDOW_BYTES = asps_pkg::WINDOW_BYTES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  asps_pkg::cmd_t                       cmd,
  output asps_pkg::stat_t                      stat,
  input  logic [7:0]                           data_byte,
  input  logic                                 cfg_write,
  input  logic [asps_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [asps_pkg::SLEEP_W-1:0]         cfg_data,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output logic                                 found,
  output logic [asps_pkg::SLEEP_W-1:0]         sleep_type_a,
  output logic [asps_pkg::SLEEP_W-1:0]         sleep_type_b
);
  import asps_pkg::*;

  localparam int unsigned FILL_W = $clog2(WINDOW_BYTES + 1);
  localparam logic [FILL_W-1:0] FULL = FILL_W'(WINDOW_BYTES);

  logic [7:0]         win [WINDOW_BYTES];
  logic [7:0]         tap [TAPS];
  logic [FILL_W-1:0]  fill;
  logic [FILL_W-1:0]  fill_inc;
  logic [FILL_W-1:0]  lead;
  logic               matched;
  logic [SLEEP_W-1:0] found_a;
  logic [SLEEP_W-1:0] found_b;
  logic [SLEEP_W-1:0] def_a;
  logic [SLEEP_W-1:0] def_b;

  logic [7:0] avail;
  logic [5:0] plen;
  logic [7:0] pend;
  logic [6:0] room0;
  logic [6:0] room1;
  logic       header_ok;
  logic       hit;
  const_t     c0;
  const_t     c1;
  logic [7:0] op1;
  logic [7:0] op1_b1;
  logic [7:0] op1_b2;

  // window: newest byte enters at the tail, head is the position under test
  always_ff @(posedge clk) begin
    if (cmd.append) begin
      for (int i = 0; i < WINDOW_BYTES - 1; i++) win[i] <= win[i + 1];
      win[WINDOW_BYTES - 1] <= data_byte;
    end else if (cmd.align || cmd.step) begin
      for (int i = 0; i < WINDOW_BYTES - 1; i++) win[i] <= win[i + 1];
      win[WINDOW_BYTES - 1] <= '0;
    end
  end

  // short windows read zeros past the end; the fill check never uses them
  for (genvar g = 0; g < TAPS; g++) begin : g_tap
    if (g < WINDOW_BYTES) begin : g_win
      assign tap[g] = win[g];
    end else begin : g_pad
      assign tap[g] = '0;
    end
  end

  assign fill_inc = (fill == FULL) ? FULL : fill + 1'b1;

  always_ff @(posedge clk) begin
    if (rst || cmd.finish) begin
      fill <= '0;
    end else if (cmd.append) begin
      fill <= fill_inc;
    end else if (cmd.step) begin
      fill <= fill - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lead <= '0;
    end else if (cmd.enter_drain) begin
      lead <= FULL - fill_inc;
    end else if (cmd.align) begin
      lead <= lead - 1'b1;
    end
  end

  // head position test
  always_comb begin
    avail     = 8'(fill);
    plen      = tap[5][5:0] & LEN_MASK;
    pend      = ELEM_OFS + {2'b00, plen};
    room0     = {1'b0, plen};
    header_ok = (tap[0] == CH_UNDER) && (tap[1] == CH_S) && (tap[2] == CH_5) &&
                (tap[3] == CH_UNDER) && (tap[4] == OP_PACKAGE) &&
                ((tap[5] & LEN_BAD) == 8'd0) && (plen != 6'd0) && (tap[6] >= MIN_COUNT);
    c0        = decode_const(tap[7], tap[8], tap[9], room0);
    case (c0.size)
      2'd1: begin
        op1 = tap[8]; op1_b1 = tap[9]; op1_b2 = tap[10];
      end
      2'd2: begin
        op1 = tap[9]; op1_b1 = tap[10]; op1_b2 = tap[11];
      end
      default: begin
        op1 = tap[10]; op1_b1 = tap[11]; op1_b2 = tap[12];
      end
    endcase
    room1 = room0 - 7'(c0.size);
    c1    = decode_const(op1, op1_b1, op1_b2, room1);
    hit   = (avail > 8'd6) && header_ok && (pend <= avail) && c0.ok &&
            (7'(c0.size) < room0) && c1.ok && c0.fits && c1.fits;
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.finish) begin
      matched <= 1'b0;
      found_a <= '0;
      found_b <= '0;
    end else if (cmd.test_en && hit) begin
      matched <= 1'b1;
      found_a <= c0.val;
      found_b <= c1.val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      def_a <= DEF_SLEEP;
      def_b <= DEF_SLEEP;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_DEF_A: def_a <= cfg_data;
        REG_DEF_B: def_b <= cfg_data;
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      found        <= matched;
      sleep_type_a <= matched ? found_a : def_a;
      sleep_type_b <= matched ? found_b : def_b;
    end
  end

  assign stat.fill_full   = (fill == FULL);
  assign stat.fill_le_one = (fill <= FILL_W'(1));
  assign stat.lead_zero   = (lead == '0);
  assign stat.matched     = matched;
  assign stat.out_free    = !out_valid || out_ready;

  `ASPS_ASSERT(a_fill_bound, clk, rst, fill <= FULL)
  `ASPS_ASSERT_NEXT(a_finish_clears, clk, rst, cmd.finish, out_valid && fill == '0 && !matched)
  `ASPS_ASSERT_NEXT(a_hit_sets_match, clk, rst, cmd.test_en && hit && !cmd.finish, matched)
  `ASPS_ASSERT(a_hit_needs_bytes, clk, rst, !hit || fill > FILL_W'(6))

endmodule
`default_nettype wire

>>> rtl/asps_ctrl.sv
// Controller: streaming versus drain of the window after the last byte.
`default_nettype none
`include "aml_sleep_package_scanner_defines.svh"
module asps_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            in_last,
  output logic            in_ready,
  input  asps_pkg::stat_t stat,
  output asps_pkg::cmd_t  cmd
);
  import asps_pkg::*;

  localparam logic ST_STREAM = 1'b0;
  localparam logic ST_DRAIN  = 1'b1;

  logic state;
  logic state_next;
  logic accept;

  assign in_ready = (state == ST_STREAM);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd             = '0;
    cmd.append      = accept;
    cmd.enter_drain = accept && in_last;
    state_next      = state;
    unique case (state)
      ST_STREAM: begin
        cmd.test_en = stat.fill_full && !stat.matched;
        if (cmd.enter_drain) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        cmd.align   = !stat.lead_zero;
        cmd.test_en = stat.lead_zero && !stat.matched;
        cmd.step    = stat.lead_zero && !stat.matched && !stat.fill_le_one;
        cmd.finish  = stat.lead_zero && (stat.matched || stat.fill_le_one) && stat.out_free;
        if (cmd.finish) state_next = ST_STREAM;
      end
      default: state_next = ST_STREAM;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_STREAM;
    end else begin
      state <= state_next;
    end
  end

  `ASPS_ASSERT_NEXT(a_last_to_drain, clk, rst, cmd.enter_drain, state == ST_DRAIN)
  `ASPS_ASSERT_NEXT(a_finish_to_stream, clk, rst, cmd.finish, state == ST_STREAM)
  `ASPS_ASSERT(a_align_alone, clk, rst, !(cmd.align && (cmd.step || cmd.finish || cmd.test_en)))

endmodule
`default_nettype wire
